// File: rtl/segint_pkg.sv
// shared constants and types for the segment intersection test
package segint_pkg;

  // default coordinate width taken from each endpoint field
  localparam int unsigned COORD_BITS_DEFAULT = 16;

  // per-pair flags that ride along with the arithmetic
  typedef struct packed {
    logic same;     // both segments identical
    logic overlap;  // x and y projections overlap with positive length
  } segint_flags_t;

endpackage

// File: rtl/segint_prep.sv
// first stage: endpoint differences, identity check and projection overlap
module segint_prep #(
  parameter int unsigned COORD_BITS = segint_pkg::COORD_BITS_DEFAULT,
  localparam int unsigned DW = COORD_BITS + 1
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  output logic                          ready_o,
  input  logic signed [COORD_BITS-1:0]  x1_i,
  input  logic signed [COORD_BITS-1:0]  y1_i,
  input  logic signed [COORD_BITS-1:0]  x2_i,
  input  logic signed [COORD_BITS-1:0]  y2_i,
  input  logic signed [COORD_BITS-1:0]  x3_i,
  input  logic signed [COORD_BITS-1:0]  y3_i,
  input  logic signed [COORD_BITS-1:0]  x4_i,
  input  logic signed [COORD_BITS-1:0]  y4_i,
  output logic                          valid_o,
  input  logic                          ready_i,
  output logic signed [DW-1:0]          d1x_o,
  output logic signed [DW-1:0]          d1y_o,
  output logic signed [DW-1:0]          d2x_o,
  output logic signed [DW-1:0]          d2y_o,
  output logic signed [DW-1:0]          rx_o,
  output logic signed [DW-1:0]          ry_o,
  output segint_pkg::segint_flags_t     flags_o
);

  logic                       valid_q;
  logic                       load;
  logic signed [DW-1:0]       d1x_d, d1y_d, d2x_d, d2y_d, rx_d, ry_d;
  logic signed [DW-1:0]       d1x_q, d1y_q, d2x_q, d2y_q, rx_q, ry_q;
  segint_pkg::segint_flags_t  flags_d, flags_q;
  logic                       ovl_x, ovl_y;

  // strict overlap of two closed intervals given in any order
  function automatic logic overlap_strict(
    input logic signed [COORD_BITS-1:0] a,
    input logic signed [COORD_BITS-1:0] b,
    input logic signed [COORD_BITS-1:0] c,
    input logic signed [COORD_BITS-1:0] d
  );
    logic signed [COORD_BITS-1:0] lo_ab, hi_ab, lo_cd, hi_cd, lo, hi;
    lo_ab = (a < b) ? a : b;
    hi_ab = (a < b) ? b : a;
    lo_cd = (c < d) ? c : d;
    hi_cd = (c < d) ? d : c;
    lo    = (lo_ab > lo_cd) ? lo_ab : lo_cd;
    hi    = (hi_ab < hi_cd) ? hi_ab : hi_cd;
    return lo < hi;
  endfunction

  // difference vectors, one bit wider than the coordinates
  always_comb begin
    d1x_d = DW'(x2_i) - DW'(x1_i);
    d1y_d = DW'(y2_i) - DW'(y1_i);
    d2x_d = DW'(x4_i) - DW'(x3_i);
    d2y_d = DW'(y4_i) - DW'(y3_i);
    rx_d  = DW'(x3_i) - DW'(x1_i);
    ry_d  = DW'(y3_i) - DW'(y1_i);
    ovl_x = overlap_strict(x1_i, x2_i, x3_i, x4_i);
    ovl_y = overlap_strict(y1_i, y2_i, y3_i, y4_i);
    flags_d.same = ((x1_i == x3_i) && (y1_i == y3_i) && (x2_i == x4_i) && (y2_i == y4_i)) ||
                   ((x1_i == x4_i) && (y1_i == y4_i) && (x2_i == x3_i) && (y2_i == y3_i));
    flags_d.overlap = ovl_x && ovl_y;
  end

  // stage handshake
  assign ready_o = !valid_q || ready_i;
  assign load    = valid_i && ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  // payload register
  always_ff @(posedge clk_i) begin
    if (load) begin
      d1x_q   <= d1x_d;
      d1y_q   <= d1y_d;
      d2x_q   <= d2x_d;
      d2y_q   <= d2y_d;
      rx_q    <= rx_d;
      ry_q    <= ry_d;
      flags_q <= flags_d;
    end
  end

  assign valid_o = valid_q;
  assign d1x_o   = d1x_q;
  assign d1y_o   = d1y_q;
  assign d2x_o   = d2x_q;
  assign d2y_o   = d2y_q;
  assign rx_o    = rx_q;
  assign ry_o    = ry_q;
  assign flags_o = flags_q;

endmodule

// File: rtl/segint_cross.sv
// second and third stages: six products, then the three cross products
module segint_cross #(
  parameter int unsigned COORD_BITS = segint_pkg::COORD_BITS_DEFAULT,
  localparam int unsigned DW = COORD_BITS + 1,
  localparam int unsigned PW = 2 * DW,
  localparam int unsigned SW = PW + 1
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       valid_i,
  output logic                       ready_o,
  input  logic signed [DW-1:0]       d1x_i,
  input  logic signed [DW-1:0]       d1y_i,
  input  logic signed [DW-1:0]       d2x_i,
  input  logic signed [DW-1:0]       d2y_i,
  input  logic signed [DW-1:0]       rx_i,
  input  logic signed [DW-1:0]       ry_i,
  input  segint_pkg::segint_flags_t  flags_i,
  output logic                       valid_o,
  input  logic                       ready_i,
  output logic signed [SW-1:0]       den_o,
  output logic signed [SW-1:0]       tn_o,
  output logic signed [SW-1:0]       un_o,
  output segint_pkg::segint_flags_t  flags_o
);

  // product stage
  logic                       pv_q, p_ready, p_load;
  logic signed [PW-1:0]       p_d1x_d2y_q, p_d1y_d2x_q;
  logic signed [PW-1:0]       p_rx_d2y_q, p_ry_d2x_q;
  logic signed [PW-1:0]       p_rx_d1y_q, p_ry_d1x_q;
  segint_pkg::segint_flags_t  pflags_q;

  // difference stage
  logic                       sv_q, s_ready, s_load;
  logic signed [SW-1:0]       den_q, tn_q, un_q;
  segint_pkg::segint_flags_t  sflags_q;

  // stage handshakes
  assign s_ready = !sv_q || ready_i;
  assign p_ready = !pv_q || s_ready;
  assign p_load  = valid_i && p_ready;
  assign s_load  = pv_q && s_ready;
  assign ready_o = p_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q <= 1'b0;
      sv_q <= 1'b0;
    end else begin
      if (p_ready) begin
        pv_q <= valid_i;
      end
      if (s_ready) begin
        sv_q <= pv_q;
      end
    end
  end

  // partial products, one register after each multiplier
  always_ff @(posedge clk_i) begin
    if (p_load) begin
      p_d1x_d2y_q <= PW'(d1x_i) * PW'(d2y_i);
      p_d1y_d2x_q <= PW'(d1y_i) * PW'(d2x_i);
      p_rx_d2y_q  <= PW'(rx_i) * PW'(d2y_i);
      p_ry_d2x_q  <= PW'(ry_i) * PW'(d2x_i);
      p_rx_d1y_q  <= PW'(rx_i) * PW'(d1y_i);
      p_ry_d1x_q  <= PW'(ry_i) * PW'(d1x_i);
      pflags_q    <= flags_i;
    end
  end

  // cross products: den = d1 x d2, tn = r x d2, un = r x d1
  always_ff @(posedge clk_i) begin
    if (s_load) begin
      den_q    <= SW'(p_d1x_d2y_q) - SW'(p_d1y_d2x_q);
      tn_q     <= SW'(p_rx_d2y_q) - SW'(p_ry_d2x_q);
      un_q     <= SW'(p_rx_d1y_q) - SW'(p_ry_d1x_q);
      sflags_q <= pflags_q;
    end
  end

  assign valid_o = sv_q;
  assign den_o   = den_q;
  assign tn_o    = tn_q;
  assign un_o    = un_q;
  assign flags_o = sflags_q;

endmodule

// File: rtl/segint_decide.sv
// last stage: range tests on the rational parameters and the output register
module segint_decide #(
  parameter int unsigned COORD_BITS = segint_pkg::COORD_BITS_DEFAULT,
  localparam int unsigned SW = 2 * (COORD_BITS + 1) + 1
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       valid_i,
  output logic                       ready_o,
  input  logic signed [SW-1:0]       den_i,
  input  logic signed [SW-1:0]       tn_i,
  input  logic signed [SW-1:0]       un_i,
  input  segint_pkg::segint_flags_t  flags_i,
  output logic                       valid_o,
  input  logic                       ready_i,
  output logic                       crosses_o,
  output logic                       equal_error_o
);

  logic valid_q, load;
  logic crosses_d, crosses_q, equal_error_q;
  logic t_in, u_in, den_pos;

  // strictly between zero and den, for either sign of den
  always_comb begin
    den_pos = !den_i[SW-1];
    if (den_pos) begin
      t_in = (tn_i > 0) && (tn_i < den_i);
      u_in = (un_i > 0) && (un_i < den_i);
    end else begin
      t_in = (tn_i < 0) && (tn_i > den_i);
      u_in = (un_i < 0) && (un_i > den_i);
    end
    // parallel lines: collinear when r x d1 is zero
    if (flags_i.same) begin
      crosses_d = 1'b0;
    end else if (den_i != '0) begin
      crosses_d = t_in && u_in;
    end else begin
      crosses_d = (un_i == '0) && flags_i.overlap;
    end
  end

  assign ready_o = !valid_q || ready_i;
  assign load    = valid_i && ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (load) begin
      crosses_q     <= crosses_d;
      equal_error_q <= flags_i.same;
    end
  end

  assign valid_o       = valid_q;
  assign crosses_o     = crosses_q;
  assign equal_error_o = equal_error_q;

endmodule

// File: rtl/segment_intersection_test.sv
// top level of the segment intersection test pipeline
//
// Takes one pair of segments per transaction on the input channel
// (valid_i/ready_o, eight signed endpoint coordinates) and returns one
// result per transaction on the output channel (valid_o/ready_i):
// crosses_o and equal_error_o. Pairs are independent; no state links them.
//
// An accepted input passes four registered stages on its way to valid_o:
// endpoint differences and compares, six signed multipliers, the three
// cross-product subtractions, and the final range tests into the output
// register. Throughput is one transaction per cycle while ready_i stays high;
// each of the four stages holds one pair.
//
// Reset clears every stage's valid bit; the pipeline comes out of reset
// empty and ready. When the receiver stalls, a stage advances only while
// the stage after it is empty or moving, so ready_o falls once all four
// stages are full and nothing is lost or repeated.
module segment_intersection_test #(
  parameter int unsigned COORD_BITS = segint_pkg::COORD_BITS_DEFAULT
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  output logic                          ready_o,
  input  logic signed [COORD_BITS-1:0]  first_start_x_i,
  input  logic signed [COORD_BITS-1:0]  first_start_y_i,
  input  logic signed [COORD_BITS-1:0]  first_end_x_i,
  input  logic signed [COORD_BITS-1:0]  first_end_y_i,
  input  logic signed [COORD_BITS-1:0]  second_start_x_i,
  input  logic signed [COORD_BITS-1:0]  second_start_y_i,
  input  logic signed [COORD_BITS-1:0]  second_end_x_i,
  input  logic signed [COORD_BITS-1:0]  second_end_y_i,
  output logic                          valid_o,
  input  logic                          ready_i,
  output logic                          crosses_o,
  output logic                          equal_error_o
);

  localparam int unsigned DW = COORD_BITS + 1;
  localparam int unsigned SW = 2 * DW + 1;

  logic                       prep_valid, prep_ready;
  logic signed [DW-1:0]       d1x, d1y, d2x, d2y, rx, ry;
  segint_pkg::segint_flags_t  prep_flags;

  logic                       cross_valid, cross_ready;
  logic signed [SW-1:0]       den, tn, un;
  segint_pkg::segint_flags_t  cross_flags;

  // differences and flags
  segint_prep #(
    .COORD_BITS (COORD_BITS)
  ) u_prep (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (valid_i),
    .ready_o (ready_o),
    .x1_i    (first_start_x_i),
    .y1_i    (first_start_y_i),
    .x2_i    (first_end_x_i),
    .y2_i    (first_end_y_i),
    .x3_i    (second_start_x_i),
    .y3_i    (second_start_y_i),
    .x4_i    (second_end_x_i),
    .y4_i    (second_end_y_i),
    .valid_o (prep_valid),
    .ready_i (prep_ready),
    .d1x_o   (d1x),
    .d1y_o   (d1y),
    .d2x_o   (d2x),
    .d2y_o   (d2y),
    .rx_o    (rx),
    .ry_o    (ry),
    .flags_o (prep_flags)
  );

  // cross products
  segint_cross #(
    .COORD_BITS (COORD_BITS)
  ) u_cross (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (prep_valid),
    .ready_o (prep_ready),
    .d1x_i   (d1x),
    .d1y_i   (d1y),
    .d2x_i   (d2x),
    .d2y_i   (d2y),
    .rx_i    (rx),
    .ry_i    (ry),
    .flags_i (prep_flags),
    .valid_o (cross_valid),
    .ready_i (cross_ready),
    .den_o   (den),
    .tn_o    (tn),
    .un_o    (un),
    .flags_o (cross_flags)
  );

  // decision and output register
  segint_decide #(
    .COORD_BITS (COORD_BITS)
  ) u_decide (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (cross_valid),
    .ready_o       (cross_ready),
    .den_i         (den),
    .tn_i          (tn),
    .un_i          (un),
    .flags_i       (cross_flags),
    .valid_o       (valid_o),
    .ready_i       (ready_i),
    .crosses_o     (crosses_o),
    .equal_error_o (equal_error_o)
  );

endmodule
